// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/kh_pkg.sv
package kh_pkg;

    localparam int HASH_W = 32;
    localparam int BYTE_W = 8;

    localparam logic FUNC_STRING  = 1'b0;
    localparam logic FUNC_INTEGER = 1'b1;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] key_byte;
        logic              byte_present;
        logic [HASH_W-1:0] int_key;
        logic              last;
    } kh_item_t;

    typedef struct packed {
        logic emit;
        logic update;
    } kh_ctrl_t;

    function automatic logic [HASH_W-1:0] sra(input logic [HASH_W-1:0] x,
                                              input int unsigned s);
        sra = HASH_W'($signed(x) >>> s);
    endfunction

    function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] t;
        t = h + {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
        t = t + (t << 10);
        t = t ^ sra(t, 6);
        mix_byte = t;
    endfunction

    function automatic logic [HASH_W-1:0] finish(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] t;
        t = h + (h << 3);
        t = t ^ sra(t, 11);
        t = t + (t << 15);
        // most negative value negates to itself
        finish = t[HASH_W-1] ? (HASH_W'(0) - t) : t;
    endfunction

endpackage

// File: hw/rtl/kh_datapath.sv
module kh_datapath (
    input  kh_pkg::kh_item_t          item,
    input  logic [kh_pkg::HASH_W-1:0] hash_in,
    output logic [kh_pkg::HASH_W-1:0] hash_out,
    output logic [kh_pkg::HASH_W-1:0] result,
    output kh_pkg::kh_ctrl_t          ctrl
);
    import kh_pkg::*;

    logic [HASH_W-1:0] mixed;

    always_comb begin
        mixed       = item.byte_present ? mix_byte(hash_in, item.key_byte) : hash_in;
        ctrl.emit   = (item.func == FUNC_INTEGER) || item.last;
        ctrl.update = (item.func == FUNC_STRING);
        hash_out    = item.last ? '0 : mixed;
        result      = (item.func == FUNC_INTEGER) ? item.int_key : finish(mixed);
    end

endmodule

// File: hw/rtl/key_hash_one_at_a_time.sv
// One-at-a-time string hash for table keys. A string key is fed one byte per
// item, and a new item is taken every cycle unless a finished result is held
// waiting on m_ready. A result passes through the input register, then the
// result register: the absolute hash after the item marked last, or the
// integer key itself for an integer item. The most negative hash is passed
// unchanged. Byte-only items give no result; an integer item leaves a string
// key in progress untouched.
module key_hash_one_at_a_time (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_func,
    input  logic [kh_pkg::BYTE_W-1:0]       s_key_byte,
    input  logic                            s_byte_present,
    input  logic signed [kh_pkg::HASH_W-1:0] s_int_key,
    input  logic                            s_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [kh_pkg::HASH_W-1:0] m_hash_value
);
    import kh_pkg::*;

    kh_item_t          item_reg;
    logic              item_valid_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] result;
    logic [HASH_W-1:0] result_reg;
    logic              out_valid_reg;
    kh_ctrl_t          ctrl;
    logic              out_free;
    logic              advance;

    kh_datapath u_datapath (
        .item     (item_reg),
        .hash_in  (hash_reg),
        .hash_out (hash_next),
        .result   (result),
        .ctrl     (ctrl)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = item_valid_reg && (!ctrl.emit || out_free);
    assign s_ready  = !item_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            hash_reg       <= '0;
        end else begin
            if (s_ready) begin
                item_valid_reg <= s_valid;
            end
            if (advance && ctrl.update) begin
                hash_reg <= hash_next;
            end
            if (advance && ctrl.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.func         <= s_func;
            item_reg.key_byte     <= s_key_byte;
            item_reg.byte_present <= s_byte_present;
            item_reg.int_key      <= HASH_W'(s_int_key);
            item_reg.last         <= s_last;
        end
        if (advance && ctrl.emit) begin
            result_reg <= result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_hash_value = $signed(result_reg);

endmodule

// File: hw/rtl/kh_checker.sv
`include "assert_macros.svh"

module kh_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic signed [kh_pkg::HASH_W-1:0] m_hash_value
);
    import kh_pkg::*;

    // a held result keeps its value
    `ASSERT_CLK_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_hash_value), "result changed while stalled")

    // input side only stalls behind a waiting result
    `ASSERT_CLK_RST(a_stall_cause, aclk, aresetn, !s_ready |-> m_valid && !m_ready, "input stalled with result side free")

    // reset empties both stages
    `ASSERT_CLK(a_reset_empty, aclk, !aresetn |=> !m_valid && s_ready, "block not empty after reset")

endmodule

bind key_hash_one_at_a_time kh_checker u_kh_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hash_value (m_hash_value)
);

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import kh_pkg::*;

    class hash_board;
        logic [HASH_W-1:0] run_hash;
        logic [HASH_W-1:0] hash_q[$];
        int fails;
        int checked;
        int string_keys;
        int integer_keys;

        function new();
            run_hash = '0;
            fails = 0;
            checked = 0;
            string_keys = 0;
            integer_keys = 0;
        endfunction

        function logic [HASH_W-1:0] fold_byte(logic [HASH_W-1:0] h, logic [BYTE_W-1:0] b);
            logic [HASH_W-1:0] t;
            t = h + {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
            t = t * 32'd1025;
            t = t ^ {{6{t[HASH_W-1]}}, t[HASH_W-1:6]};
            return t;
        endfunction

        function logic [HASH_W-1:0] avalanche(logic [HASH_W-1:0] h);
            logic [HASH_W-1:0] t;
            t = h * 32'd9;
            t = t ^ {{11{t[HASH_W-1]}}, t[HASH_W-1:11]};
            t = t * 32'd32769;
            if (t[HASH_W-1])
                t = ~t + 32'd1;
            return t;
        endfunction

        function void note_item(kh_item_t it);
            if (it.func == FUNC_INTEGER) begin
                hash_q = {hash_q, it.int_key};
                integer_keys++;
            end else begin
                if (it.byte_present)
                    run_hash = fold_byte(run_hash, it.key_byte);
                if (it.last) begin
                    hash_q = {hash_q, avalanche(run_hash)};
                    run_hash = '0;
                    string_keys++;
                end
            end
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            fails++;
        endtask

        task check_hash(logic [HASH_W-1:0] got);
            logic [HASH_W-1:0] want;
            if (hash_q.size() == 0) begin
                report($sformatf("unexpected hash_value %h", got));
            end else begin
                want = hash_q.pop_front();
                checked++;
                if (got !== want)
                    report($sformatf("hash_value %h, expected %h", got, want));
            end
        endtask
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_func = FUNC_STRING;
    logic [BYTE_W-1:0]        s_key_byte = '0;
    logic                     s_byte_present = 1'b0;
    logic signed [HASH_W-1:0] s_int_key = '0;
    logic                     s_last = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [HASH_W-1:0] m_hash_value;

    hash_board sb = new();

    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    bit hold_req = 1'b0;
    int counted = 0;

    key_hash_one_at_a_time uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_key_byte     (s_key_byte),
        .s_byte_present (s_byte_present),
        .s_int_key      (s_int_key),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash_value   (m_hash_value)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic kh_item_t mk(logic f, logic [BYTE_W-1:0] b, logic p,
                                    logic [HASH_W-1:0] k, logic l);
        kh_item_t it;
        it.func = f;
        it.key_byte = b;
        it.byte_present = p;
        it.int_key = k;
        it.last = l;
        return it;
    endfunction

    // called at a falling edge, returns at a falling edge
    task drive_item(kh_item_t it);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_calm = ~tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_func         <= it.func;
        s_key_byte     <= it.key_byte;
        s_byte_present <= it.byte_present;
        s_int_key      <= it.int_key;
        s_last         <= it.last;
        s_valid        <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        if (it.func == FUNC_INTEGER || it.byte_present || it.last)
            counted++;
        @(negedge aclk);
    endtask

    task send_int_item();
        drive_item(mk(FUNC_INTEGER, 8'($urandom), 1'($urandom_range(0, 1)), $urandom,
                      1'($urandom_range(0, 1))));
    endtask

    task send_string_key();
        int len;
        bit empty_end;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        empty_end = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 23))
                0: send_int_item();
                1: drive_item(mk(FUNC_STRING, 8'($urandom), 1'b0, $urandom, 1'b0));
                default: ;
            endcase
            drive_item(mk(FUNC_STRING, 8'($urandom), 1'b1, $urandom,
                          (i == len - 1) && !empty_end));
        end
        if (empty_end)
            drive_item(mk(FUNC_STRING, 8'($urandom), 1'b0, $urandom, 1'b1));
    endtask

    task run_directed();
        // empty key straight after reset, then an ignored item
        drive_item(mk(FUNC_STRING, 8'h00, 1'b0, 32'h0, 1'b1));
        drive_item(mk(FUNC_STRING, 8'hff, 1'b0, 32'hffffffff, 1'b0));
        // integer keys at the extremes, most negative passed as is
        drive_item(mk(FUNC_INTEGER, 8'hff, 1'b1, 32'h80000000, 1'b1));
        drive_item(mk(FUNC_INTEGER, 8'h00, 1'b0, 32'h7fffffff, 1'b0));
        drive_item(mk(FUNC_INTEGER, 8'h80, 1'b1, 32'hffffffff, 1'b0));
        drive_item(mk(FUNC_INTEGER, 8'h7f, 1'b0, 32'h00000000, 1'b1));
        // single-byte keys, zero byte included, then a two-byte key
        drive_item(mk(FUNC_STRING, 8'h00, 1'b1, 32'h0, 1'b1));
        drive_item(mk(FUNC_STRING, 8'hff, 1'b1, 32'hffffffff, 1'b1));
        drive_item(mk(FUNC_STRING, 8'h7f, 1'b1, 32'h0, 1'b0));
        drive_item(mk(FUNC_STRING, 8'h80, 1'b1, 32'h0, 1'b1));
        // integer and idle items inside a string key
        drive_item(mk(FUNC_STRING, 8'h61, 1'b1, 32'h0, 1'b0));
        drive_item(mk(FUNC_INTEGER, 8'h00, 1'b0, 32'h12345678, 1'b0));
        drive_item(mk(FUNC_STRING, 8'h00, 1'b0, 32'h0, 1'b0));
        drive_item(mk(FUNC_STRING, 8'h62, 1'b1, 32'h0, 1'b1));
        // key closed by an empty end, then a two-byte key
        drive_item(mk(FUNC_STRING, 8'h63, 1'b1, 32'h0, 1'b0));
        drive_item(mk(FUNC_STRING, 8'h00, 1'b1, 32'h0, 1'b0));
        drive_item(mk(FUNC_STRING, 8'h00, 1'b0, 32'haaaaaaaa, 1'b1));
        drive_item(mk(FUNC_STRING, 8'h55, 1'b1, 32'h55555555, 1'b0));
        drive_item(mk(FUNC_STRING, 8'haa, 1'b1, 32'h0, 1'b1));
    endtask

    initial begin
        int r;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        run_directed();
        hold_req = 1'b1;
        while (counted < 650) begin
            r = $urandom_range(0, 99);
            if (r < 12)
                send_int_item();
            else if (r < 16)
                drive_item(mk(FUNC_STRING, 8'($urandom), 1'b0, $urandom, 1'b1));
            else if (r < 22)
                drive_item(mk(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)),
                              $urandom, 1'($urandom_range(0, 1))));
            else
                send_string_key();
        end
        // close any key left open by noise
        drive_item(mk(FUNC_STRING, 8'h00, 1'b0, 32'h0, 1'b1));
        s_valid <= 1'b0;
        while (sb.hash_q.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("%0d string keys and %0d integer keys hashed, %0d results checked",
                 sb.string_keys, sb.integer_keys, sb.checked);
        if (sb.fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        int stall;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                rx_calm = ~rx_calm;
            if (hold_req) begin
                hold_req = 1'b0;
                stall = 300;
            end else begin
                stall = rx_calm ? 0 : $urandom_range(0, 16);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_hash(m_hash_value);
            @(negedge aclk);
        end
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
